// ----- rtl/core/tmvm_pkg.sv -----
// Shared constants for the transposed matrix-vector multiply-accumulate core.
`timescale 1ns / 1ps

package tmvm_pkg;

	// Largest matrix dimension and the width of a row or column index.
	localparam int MAX_SIZE = 1024;
	localparam int IDX_W    = $clog2(MAX_SIZE);

	// Element, product and accumulator widths (Q8.8 in, Q16.16 products, Q32.16 sums out).
	localparam int ELEM_W = 16;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int SUM_W  = 48;

	// Size register width and its value after reset.
	localparam int SIZE_W = 11;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

	// Stream payload widths, padded to whole bytes.
	localparam int IN_DATA_W  = ((2 * ELEM_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((SUM_W + IDX_W + 7) / 8) * 8;

endpackage

// ----- rtl/core/tmvm_acc_ram.sv -----
// Column accumulator memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module tmvm_acc_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [tmvm_pkg::IDX_W-1:0]   waddr,
	input  logic [tmvm_pkg::SUM_W-1:0]   wdata,
	input  logic                         re,
	input  logic [tmvm_pkg::IDX_W-1:0]   raddr,
	output logic [tmvm_pkg::SUM_W-1:0]   rdata
);
	import tmvm_pkg::*;

	logic [SUM_W-1:0] mem [MAX_SIZE];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the read data is registered and updates only while re is high.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/transposed_matrix_vector_mac_core.sv -----
// Top level of the transposed matrix-vector multiply-accumulate core.
//
// Channel   Direction  Transaction contents
// s_axis    in         one matrix element A[i][j] with the vector element x[i]
// m_axis    out        finished sum of column j, its index, last-column flag
// cfg       in         matrix dimension n (write only)
//
// One element is taken per cycle unless a result waits in the output register;
// a column's result passes stage 1, stage 2 and the output register. The path
// is a read-modify-write of the column accumulator memory over two stages, with
// the sum forwarded when the next element hits the same column. All stages move
// together and stop only while an untaken result sits in the output register.
// Reset clears the counters and sets n to 1024; accumulators need no clearing.
`timescale 1ns / 1ps

module transposed_matrix_vector_mac_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write.
	input  logic                               cfg_we,
	input  logic [tmvm_pkg::SIZE_W-1:0]        cfg_wdata,   // size_in_use
	// Input stream.
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [tmvm_pkg::IN_DATA_W-1:0]     s_axis_tdata, // matrix_element, vector_element
	// Output stream.
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [tmvm_pkg::OUT_DATA_W-1:0]    m_axis_tdata, // column_sum, column_index, pad
	output logic                               m_axis_tlast   // last_column
);
	import tmvm_pkg::*;

	// Configuration and position counters.
	logic [IDX_W-1:0] last_idx_q;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;

	// Stage 1: operands and position flags.
	logic                     valid_s1;
	logic signed [ELEM_W-1:0] a_s1;
	logic signed [ELEM_W-1:0] x_s1;
	logic [IDX_W-1:0]         col_s1;
	logic                     first_row_s1;
	logic                     last_row_s1;
	logic                     last_col_s1;

	// Stage 2: product, memory data and forwarding.
	logic                     valid_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic [IDX_W-1:0]         col_s2;
	logic                     first_row_s2;
	logic                     last_row_s2;
	logic                     last_col_s2;
	logic                     fwd_s2;
	logic [SUM_W-1:0]         fwd_data_s2;
	logic [SUM_W-1:0]         rd_data;

	// Output register.
	logic             out_valid_q;
	logic [SUM_W-1:0] out_sum_q;
	logic [IDX_W-1:0] out_col_q;
	logic             out_last_q;

	logic             adv;
	logic             in_acc;
	logic [SIZE_W-1:0] size_eff;
	logic [SUM_W-1:0] base;
	logic [SUM_W-1:0] sum;

	// The whole pipeline moves unless a result waits in the output register.
	assign adv           = !(out_valid_q && !m_axis_tready);
	assign s_axis_tready = adv;
	assign in_acc        = s_axis_tvalid && adv;

	// Clamp the written size to the range one to the maximum.
	always_comb begin
		priority if (cfg_wdata == '0) begin
			size_eff = SIZE_W'(1);
		end else if (cfg_wdata > SIZE_W'(MAX_SIZE)) begin
			size_eff = SIZE_W'(MAX_SIZE);
		end else begin
			size_eff = cfg_wdata;
		end
	end

	// Size register and row/column counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_idx_q <= IDX_W'(SIZE_RESET - SIZE_W'(1));
			row_q      <= '0;
			col_q      <= '0;
		end else if (cfg_we) begin
			last_idx_q <= IDX_W'(size_eff - SIZE_W'(1));
			row_q      <= '0;
			col_q      <= '0;
		end else if (in_acc) begin
			if (col_q == last_idx_q) begin
				col_q <= '0;
				row_q <= (row_q == last_idx_q) ? '0 : row_q + IDX_W'(1);
			end else begin
				col_q <= col_q + IDX_W'(1);
			end
		end
	end

	// Stage 1 valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_s1         <= s_axis_tdata[ELEM_W-1:0];
			x_s1         <= s_axis_tdata[2*ELEM_W-1:ELEM_W];
			col_s1       <= col_q;
			first_row_s1 <= (row_q == '0);
			last_row_s1  <= (row_q == last_idx_q);
			last_col_s1  <= (col_q == last_idx_q);
		end
	end

	// Stage 2 valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload; catch the sum when it is written to the column now read.
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2      <= a_s1 * x_s1;
			col_s2       <= col_s1;
			first_row_s2 <= first_row_s1;
			last_row_s2  <= last_row_s1;
			last_col_s2  <= last_col_s1;
			fwd_s2       <= valid_s2 && (col_s2 == col_s1);
			fwd_data_s2  <= sum;
		end
	end

	// Accumulate: row 0 starts from zero, later rows from memory or forward.
	always_comb begin
		priority if (first_row_s2) begin
			base = '0;
		end else if (fwd_s2) begin
			base = fwd_data_s2;
		end else begin
			base = rd_data;
		end
		sum = base + {{(SUM_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	end

	tmvm_acc_ram u_acc_ram (
		.clk   (clk),
		.we    (adv && valid_s2),
		.waddr (col_s2),
		.wdata (sum),
		.re    (adv),
		.raddr (col_s1),
		.rdata (rd_data)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2 && last_row_s2;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_sum_q  <= sum;
			out_col_q  <= col_s2;
			out_last_q <= last_col_s2;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-SUM_W-IDX_W){1'b0}}, out_col_q, out_sum_q};
	assign m_axis_tlast  = out_last_q;

	// Counters never pass the last index of the current size.
	assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= last_idx_q) && (col_q <= last_idx_q))
		else $error("position counter beyond matrix size");

	// A new result comes only from a last-row element leaving stage 2.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(valid_s2 && last_row_s2))
		else $error("result without a last-row element");

	// The flagged result belongs to the final column.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (out_col_q == last_idx_q))
		else $error("last column flag on wrong column");

	// An element that follows a write to its own column must take the forward.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s1 && valid_s2 && (col_s1 == col_s2)) |=> fwd_s2)
		else $error("missed forward of same-column sum");

endmodule
